/* sv/fqsr_pkg.sv */
// package: opcode and status codes, command struct and defaults for the search-replace queue
`default_nettype none
package fqsr_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_PUSH    = 2'd0;
    localparam opcode_t OP_POP     = 2'd1;
    localparam opcode_t OP_REPLACE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    // broadcast to every cell for one accepted beat
    typedef struct packed {
        logic  do_push;
        logic  do_pop;
        logic  do_replace;
        word_t value;
        word_t new_value;
    } cell_cmd_t;

    // per-cell position relative to the fill count
    typedef struct packed {
        logic occupied;
        logic tail;
    } cell_ctl_t;

endpackage
`default_nettype wire

/* sv/fqsr_if.sv */
// interfaces: request and response channels with valid/ready handshake
`default_nettype none
interface fqsr_req_if;
    import fqsr_pkg::*;
    logic    valid;
    logic    ready;
    opcode_t opcode;
    word_t   value;
    word_t   new_value;

    modport source (output valid, output opcode, output value, output new_value, input ready);
    modport sink   (input valid, input opcode, input value, input new_value, output ready);
endinterface

interface fqsr_rsp_if;
    import fqsr_pkg::*;
    logic    valid;
    logic    ready;
    word_t   pop_data;
    logic    matched;
    status_t status;

    modport source (output valid, output pop_data, output matched, output status, input ready);
    modport sink   (input valid, input pop_data, input matched, input status, output ready);
endinterface
`default_nettype wire

/* sv/fqsr_cell.sv */
// one queue cell: holds an entry, shifts from its neighbor on pop, compares on replace
`default_nettype none
module fqsr_cell
    import fqsr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire cell_ctl_t ctl,
    input  wire word_t     next_data,
    output word_t          data,
    output logic           hit
);

    word_t data_reg;
    word_t data_next;
    logic  hit_reg;
    logic  hit_next;
    logic  eq;

    assign eq = ctl.occupied && (data_reg == cmd.value);

    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        if (cmd.do_push)
        begin
            hit_next = 1'b0;
            if (ctl.tail)
            begin
                data_next = cmd.value;
            end
        end
        else if (cmd.do_pop)
        begin
            hit_next  = 1'b0;
            data_next = next_data;
        end
        else if (cmd.do_replace)
        begin
            hit_next = eq;
            if (eq)
            begin
                data_next = cmd.new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule
`default_nettype wire

/* sv/fifo_queue_search_replace.sv */
// top level: row of queue cells, fill count, match reduction and response register
//
//  channel | role | beat carries
//  --------+------+---------------------------------
//  req     | sink | opcode, value, new_value
//  rsp     | src  | pop_data, matched, status
//
// a request beat updates every cell in the cycle it is taken; the per-cell match
// bits are registered and ored into the response register once it is free to load.
// a new request is not taken until the last one has moved to the response register.
// rst_n clears the fill count and all handshake state; entries stay unwritten.
// a stalled response holds the next request off only once its reduction stage is full.
`default_nettype none
module fifo_queue_search_replace
    import fqsr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fqsr_req_if.sink   req,
    fqsr_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             busy_reg;
    word_t            pend_pop_reg;
    status_t          pend_status_reg;
    logic             pend_repl_reg;
    logic             out_valid_reg;
    word_t            out_pop_reg;
    logic             out_matched_reg;
    status_t          out_status_reg;

    logic             take;
    logic             full;
    logic             empty;
    logic             load_out;
    cell_cmd_t        cmd;
    status_t          status_now;
    word_t            pop_now;
    word_t            cell_data [CAPACITY];
    logic [CAPACITY-1:0] hit;

    assign full     = (count_reg == CAP_CNT);
    assign empty    = (count_reg == '0);
    assign req.ready = !busy_reg;
    assign take     = req.valid && req.ready;
    assign load_out = busy_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        cmd.do_push    = 1'b0;
        cmd.do_pop     = 1'b0;
        cmd.do_replace = 1'b0;
        cmd.value      = req.value;
        cmd.new_value  = req.new_value;
        status_now     = ST_OK;
        pop_now        = '0;
        count_next     = count_reg;
        if (take)
        begin
            case (req.opcode)
                OP_PUSH:
                begin
                    if (full)
                    begin
                        status_now = ST_FULL;
                    end
                    else
                    begin
                        cmd.do_push = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        status_now = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.do_pop = 1'b1;
                        pop_now    = cell_data[0];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_REPLACE:
                begin
                    cmd.do_replace = 1'b1;
                end
                default:
                begin
                    status_now = ST_OK;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        cell_ctl_t ctl;
        word_t     nbr;

        assign ctl.occupied = (IDX < count_reg);
        assign ctl.tail     = (IDX == count_reg);
        // last cell has no neighbor behind it; what it shifts in is never read
        assign nbr = (i == CAPACITY - 1) ? cell_data[i] : cell_data[(i + 1) % CAPACITY];

        fqsr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .ctl       (ctl),
            .next_data (nbr),
            .data      (cell_data[i]),
            .hit       (hit[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (take)
            begin
                busy_reg <= 1'b1;
            end
            else if (load_out)
            begin
                busy_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_pop_reg    <= pop_now;
            pend_status_reg <= status_now;
            pend_repl_reg   <= cmd.do_replace;
        end
        if (load_out)
        begin
            out_pop_reg     <= pend_pop_reg;
            out_status_reg  <= pend_status_reg;
            out_matched_reg <= pend_repl_reg && (|hit);
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.pop_data = out_pop_reg;
    assign rsp.matched  = out_matched_reg;
    assign rsp.status   = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("fill count above capacity");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && req.opcode == OP_PUSH && !full) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not grow the queue");

    a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_EMPTY) |-> (out_pop_reg == '0 && !out_matched_reg))
        else $error("empty pop returned data");

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_valid_reg && !rsp.ready) |=> busy_reg)
        else $error("pending result lost while response stalled");

endmodule
`default_nettype wire
